// ===== sv/dtcp_pkg.sv =====
package dtcp_pkg;

  localparam int CHUNK_LEN = 4;
  localparam int FILL_W    = $clog2(CHUNK_LEN + 1);
  localparam int IDX_W     = (CHUNK_LEN > 1) ? $clog2(CHUNK_LEN) : 1;
  localparam int VAL_W     = 19;
  localparam int LVL_W     = 4;
  localparam int SAMPLE_W  = 32;
  localparam int ACC_W     = 64;
  localparam int PEND_W    = 7;
  localparam int NB_W      = 5;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 5;
  localparam int LEVEL_SHIFT = 28;
  localparam int WORD_BITS   = 32;

  localparam logic [63:0] WIDTH_TABLE = 64'h4444444433332211;
  localparam logic [7:0]  STEP_CODES  = 8'h13;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_BITS = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DS_MODE     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_LEVEL   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PRED_EN     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_FLIP_EN     = 3'd4;

  // bit-field sources for the packer
  localparam logic [2:0] PUT_LEVEL = 3'd0;
  localparam logic [2:0] PUT_FIRST = 3'd1;
  localparam logic [2:0] PUT_HDR   = 3'd2;
  localparam logic [2:0] PUT_LONG  = 3'd3;
  localparam logic [2:0] PUT_STEP  = 3'd4;
  localparam logic [2:0] PUT_VAL   = 3'd5;

  typedef struct packed {
    logic       accept;
    logic       put;
    logic [2:0] put_sel;
    logic       calc;
    logic       prep;
    logic       flush;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic ds;
    logic chunk_full;
    logic long_hdr;
    logic j_last;
    logic out_free;
  } sts_t;

  function automatic logic [2:0] width_code(logic [3:0] idx);
    return WIDTH_TABLE[{idx, 2'b00} +: 3];
  endfunction

endpackage

// ===== sv/delta_trace_chunk_packer.sv =====
// Channel  Dir  tdata (low bit up)                      tuser  tlast
// in_      in   sample[31:0]                            -      last sample of trace
// out_     out  word[31:0], valid_bits[37:32], pad 0    -      final word of trace
// cfg_     in   write enable, index, 5-bit data         -      -
//
// A sample not closing a chunk is accepted, then differenced. A closing sample
// is prepped, then appends the header fields, a step code per value (ds mode) and
// each value, all through a single shared bit appender; the first sample appends
// its level (ds mode), then its value. A trace end adds a flush. Appends and flush
// wait while out_tready low holds a word. Reset (rst_n low, synchronous) restores
// the default registers and makes the next sample the first of a trace.
module delta_trace_chunk_packer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dtcp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [dtcp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [31:0]                         in_tdata,  // sample[31:0]
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [39:0]                         out_tdata, // word[31:0], valid_bits[37:32]
  output logic                                out_tlast
);

  dtcp_pkg::cmd_t cmd;
  dtcp_pkg::sts_t sts;
  logic [31:0]    word;
  logic [5:0]     vbits;

  dtcp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dtcp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_sample (in_tdata),
    .in_last   (in_tlast),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (word),
    .out_vbits (vbits),
    .out_final (out_tlast)
  );

  assign out_tdata = {2'b00, vbits, word};

endmodule

// ===== sv/dtcp_ctrl.sv =====
module dtcp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  dtcp_pkg::sts_t  sts,
  output dtcp_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FHDR = 4'd1;
  localparam logic [3:0] S_FVAL = 4'd2;
  localparam logic [3:0] S_CALC = 4'd3;
  localparam logic [3:0] S_PREP = 4'd4;
  localparam logic [3:0] S_HDR  = 4'd5;
  localparam logic [3:0] S_LONG = 4'd6;
  localparam logic [3:0] S_STEP = 4'd7;
  localparam logic [3:0] S_VAL  = 4'd8;
  localparam logic [3:0] S_FLSH = 4'd9;

  logic [3:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.accept  = in_tvalid && in_tready;
    case (state_r)
      S_IDLE: begin
        if (cmd.accept) begin
          if (sts.first) state_nxt = sts.ds ? S_FHDR : S_FVAL;
          else           state_nxt = S_CALC;
        end
      end
      S_FHDR: begin
        cmd.put_sel = dtcp_pkg::PUT_LEVEL;
        if (sts.out_free) begin
          cmd.put   = 1'b1;
          state_nxt = S_FVAL;
        end
      end
      S_FVAL: begin
        cmd.put_sel = dtcp_pkg::PUT_FIRST;
        if (sts.out_free) begin
          cmd.put   = 1'b1;
          state_nxt = sts.last ? S_FLSH : S_IDLE;
        end
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = (sts.chunk_full || sts.last) ? S_PREP : S_IDLE;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_HDR;
      end
      S_HDR: begin
        cmd.put_sel = dtcp_pkg::PUT_HDR;
        if (sts.out_free) begin
          cmd.put = 1'b1;
          if (sts.long_hdr) state_nxt = S_LONG;
          else              state_nxt = sts.ds ? S_STEP : S_VAL;
        end
      end
      S_LONG: begin
        cmd.put_sel = dtcp_pkg::PUT_LONG;
        if (sts.out_free) begin
          cmd.put   = 1'b1;
          state_nxt = sts.ds ? S_STEP : S_VAL;
        end
      end
      S_STEP: begin
        cmd.put_sel = dtcp_pkg::PUT_STEP;
        if (sts.out_free) begin
          cmd.put   = 1'b1;
          state_nxt = S_VAL;
        end
      end
      S_VAL: begin
        cmd.put_sel = dtcp_pkg::PUT_VAL;
        if (sts.out_free) begin
          cmd.put = 1'b1;
          if (sts.j_last)  state_nxt = sts.last ? S_FLSH : S_IDLE;
          else             state_nxt = sts.ds ? S_STEP : S_VAL;
        end
      end
      S_FLSH: begin
        if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ===== sv/dtcp_dp.sv =====
module dtcp_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dtcp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [dtcp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [dtcp_pkg::SAMPLE_W-1:0]       in_sample,
  input  logic                                in_last,
  input  dtcp_pkg::cmd_t                      cmd,
  output dtcp_pkg::sts_t                      sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [31:0]                         out_word,
  output logic [5:0]                          out_vbits,
  output logic                                out_final
);

  localparam int VW = dtcp_pkg::VAL_W;
  localparam int NW = dtcp_pkg::NB_W;

  // configuration
  logic [4:0] sbits_r;
  logic       ds_r, pred_r, flip_en_r;
  logic [3:0] maxlvl_r;

  // trace state
  logic [dtcp_pkg::SAMPLE_W-1:0] sample_r;
  logic                          last_r, first_r;
  logic [VW-1:0]                 prev_r, h0_r, h1_r, h2_r;
  logic [dtcp_pkg::LVL_W-1:0]    plvl_r;
  logic                          flip_r;
  logic [NW-1:0]                 pw_r, numbits_r, nd_r, nd2_r;
  logic [VW-1:0]                 cv_r [dtcp_pkg::CHUNK_LEN];
  logic [1:0]                    cs_r [dtcp_pkg::CHUNK_LEN];
  logic [dtcp_pkg::FILL_W-1:0]   fill_r;
  logic [dtcp_pkg::IDX_W-1:0]    j_r;
  logic [dtcp_pkg::ACC_W-1:0]    acc_r;
  logic [dtcp_pkg::PEND_W-1:0]   pend_r;
  logic                          ovalid_r, ofinal_r;
  logic [31:0]                   oword_r;
  logic [5:0]                    ovbits_r;

  // effective width, mask, sign bit
  logic [NW-1:0] bits;
  logic [VW-1:0] mask, signbit;
  always_comb begin
    if (sbits_r < 5'd4)       bits = 5'd4;
    else if (sbits_r > 5'd19) bits = 5'd19;
    else                      bits = sbits_r;
    mask    = ~({VW{1'b1}} << bits);
    signbit = VW'(1) << (bits - 5'd1);
  end

  logic [dtcp_pkg::LVL_W-1:0] level;
  assign level = sample_r[dtcp_pkg::LEVEL_SHIFT +: dtcp_pkg::LVL_W];

  // difference path
  logic [1:0]    step;
  logic [VW-1:0] smp, diff, sd, st;
  logic          same_sign;
  always_comb begin
    smp  = sample_r[VW-1:0];
    step = 2'(level - plvl_r);
    if (ds_r) diff = ((smp << step[1]) - (prev_r << (step == 2'd1))) & mask;
    else      diff = (smp - prev_r) & mask;
    same_sign = pred_r && ((((h0_r & h1_r & h2_r) |
                ((-h0_r) & (-h1_r) & (-h2_r))) & signbit) != '0);
    sd = same_sign ? ((diff - h0_r) & mask) : diff;
    st = (flip_en_r && flip_r) ? ((-sd) & mask) : sd;
  end

  // chunk width and header
  logic [VW-1:0]     all_or;
  logic [NW-1:0]     nb, pw;
  logic signed [6:0] nd, nd2;
  always_comb begin
    all_or = '0;
    for (int i = 0; i < dtcp_pkg::CHUNK_LEN; i++) begin
      if (i < int'(fill_r))
        all_or |= ((cv_r[i] & mask) ^ (((cv_r[i] & signbit) != '0) ? mask : '0)) & mask;
    end
    nb = 5'd1;
    for (int b = 0; b < VW; b++) begin
      if (all_or[b]) nb = NW'(b + 2);
    end
    if (pw_r < 5'd1)       pw = 5'd1;
    else if (pw_r > bits)  pw = bits;
    else                   pw = pw_r;
    nd = $signed({2'b00, nb}) - $signed({2'b00, pw}) + 7'sd2;
    if (nd < 0)                              nd = nd + $signed({2'b00, bits});
    else if (nd > $signed({2'b00, bits}))    nd = nd - $signed({2'b00, bits});
    nd2 = nd - 7'sd4;
    if (nd2 < 0) nd2 = nd2 + $signed({2'b00, bits});
  end

  logic short_hdr;
  assign short_hdr = (nd_r >= 5'd1) && (nd_r <= 5'd3);

  // bit field selection
  logic [VW-1:0] pv, base;
  logic [NW-1:0] pn;
  logic [1:0]    cs_j;
  always_comb begin
    cs_j = cs_r[j_r];
    base = -(VW'(1) << (numbits_r - 5'd1));
    pv   = '0;
    pn   = 5'd2;
    case (cmd.put_sel)
      dtcp_pkg::PUT_LEVEL: begin
        pv = VW'(level);
        pn = NW'(dtcp_pkg::width_code(maxlvl_r));
      end
      dtcp_pkg::PUT_FIRST: begin
        pv = (smp ^ signbit) & mask;
        pn = bits;
      end
      dtcp_pkg::PUT_HDR: begin
        pv = short_hdr ? VW'(nd_r) : '0;
        pn = 5'd2;
      end
      dtcp_pkg::PUT_LONG: begin
        pv = VW'(nd2_r);
        pn = NW'(dtcp_pkg::width_code(4'(bits - 5'd4)));
      end
      dtcp_pkg::PUT_STEP: begin
        if (cs_j == 2'd0) begin
          pv = '0;
          pn = 5'd1;
        end else if (cs_j == 2'd1) begin
          pv = VW'(dtcp_pkg::STEP_CODES[5:4]);
        end else begin
          pv = VW'(dtcp_pkg::STEP_CODES[1:0]);
        end
      end
      dtcp_pkg::PUT_VAL: begin
        pv = cv_r[j_r] - base;
        pn = numbits_r;
      end
      default: begin
        pv = '0;
        pn = 5'd2;
      end
    endcase
  end

  // bit appender
  logic [VW-1:0]                 pvm;
  logic [dtcp_pkg::ACC_W-1:0]    acc_sum;
  logic [dtcp_pkg::PEND_W-1:0]   pend_sum;
  logic                          spill;
  always_comb begin
    pvm      = pv & ~({VW{1'b1}} << pn);
    acc_sum  = acc_r | ({{(dtcp_pkg::ACC_W - VW){1'b0}}, pvm} << pend_r);
    pend_sum = pend_r + dtcp_pkg::PEND_W'(pn);
    spill    = pend_sum > dtcp_pkg::PEND_W'(dtcp_pkg::WORD_BITS);
  end

  logic [dtcp_pkg::FILL_W-1:0] fill_inc;
  assign fill_inc = fill_r + 1'b1;

  assign sts.first      = first_r;
  assign sts.last       = last_r;
  assign sts.ds         = ds_r;
  assign sts.chunk_full = (fill_inc == dtcp_pkg::FILL_W'(dtcp_pkg::CHUNK_LEN));
  assign sts.long_hdr   = !short_hdr;
  assign sts.j_last     = (dtcp_pkg::FILL_W'(j_r) + 1'b1 == fill_r);
  assign sts.out_free   = !ovalid_r || out_ready;

  assign out_valid = ovalid_r;
  assign out_word  = oword_r;
  assign out_vbits = ovbits_r;
  assign out_final = ofinal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sbits_r   <= 5'd16;
      ds_r      <= 1'b0;
      maxlvl_r  <= 4'd7;
      pred_r    <= 1'b0;
      flip_en_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        dtcp_pkg::REG_SAMPLE_BITS: sbits_r   <= cfg_wdata;
        dtcp_pkg::REG_DS_MODE:     ds_r      <= cfg_wdata[0];
        dtcp_pkg::REG_MAX_LEVEL:   maxlvl_r  <= cfg_wdata[3:0];
        dtcp_pkg::REG_PRED_EN:     pred_r    <= cfg_wdata[0];
        dtcp_pkg::REG_FLIP_EN:     flip_en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= in_sample;
      last_r   <= in_last;
    end
    if (cmd.calc) begin
      cv_r[fill_r[dtcp_pkg::IDX_W-1:0]] <= st;
      cs_r[fill_r[dtcp_pkg::IDX_W-1:0]] <= step;
    end
    if (cmd.prep) begin
      numbits_r <= nb;
      nd_r      <= nd[NW-1:0];
      nd2_r     <= nd2[NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= 1'b1;
      prev_r   <= '0;
      h0_r     <= '0;
      h1_r     <= '0;
      h2_r     <= '0;
      plvl_r   <= '0;
      flip_r   <= 1'b0;
      pw_r     <= '0;
      fill_r   <= '0;
      j_r      <= '0;
      acc_r    <= '0;
      pend_r   <= '0;
      ovalid_r <= 1'b0;
      oword_r  <= '0;
      ovbits_r <= '0;
      ofinal_r <= 1'b0;
    end else begin
      if (out_ready && !(cmd.put && spill) && !cmd.flush) ovalid_r <= 1'b0;

      if (cmd.put) begin
        if (spill) begin
          ovalid_r <= 1'b1;
          oword_r  <= acc_sum[31:0];
          ovbits_r <= 6'd32;
          ofinal_r <= 1'b0;
          acc_r    <= acc_sum >> dtcp_pkg::WORD_BITS;
          pend_r   <= pend_sum - dtcp_pkg::PEND_W'(dtcp_pkg::WORD_BITS);
        end else begin
          acc_r  <= acc_sum;
          pend_r <= pend_sum;
        end
        if (cmd.put_sel == dtcp_pkg::PUT_FIRST) begin
          prev_r  <= smp & mask;
          h0_r    <= smp & mask;
          h1_r    <= '0;
          h2_r    <= '0;
          plvl_r  <= level;
          flip_r  <= (smp & signbit) != '0;
          pw_r    <= bits;
          fill_r  <= '0;
          first_r <= 1'b0;
        end
        if (cmd.put_sel == dtcp_pkg::PUT_VAL) begin
          if (sts.j_last) begin
            j_r    <= '0;
            fill_r <= '0;
            pw_r   <= numbits_r;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
      end

      if (cmd.calc) begin
        prev_r <= smp;
        plvl_r <= level;
        h2_r   <= h1_r;
        h1_r   <= h0_r;
        h0_r   <= diff;
        if (sd != '0) flip_r <= (sd & signbit) != '0;
        fill_r <= fill_inc;
      end

      if (cmd.flush) begin
        ovalid_r <= 1'b1;
        oword_r  <= acc_r[31:0];
        ovbits_r <= pend_r[5:0];
        ofinal_r <= 1'b1;
        acc_r    <= '0;
        pend_r   <= '0;
        fill_r   <= '0;
        first_r  <= 1'b1;
      end
    end
  end

endmodule

// ===== sv/dtcp_chk.sv =====
module dtcp_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);

  // held word stays put until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  // only the final word may be partial
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[37:32] == 6'd32)
    else $error("non-final word not full");

  a_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[37:32] != 6'd0 && out_tdata[39:38] == 2'b00)
    else $error("bad valid_bits field");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // one sample in flight: input closes right after a transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a transfer");

endmodule

bind delta_trace_chunk_packer dtcp_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
